// File: hw/rtl/sbp_pkg.sv
`timescale 1ns / 1ps

package sbp_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int SKIP_CHUNKS = 3;
    localparam int LANES       = 4;

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int SKIP_W = 2;
    localparam int LANE_W = $clog2(LANES);

    localparam logic [1:0] MODE_DATA    = 2'd0;
    localparam logic [1:0] MODE_LOAD    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;
    localparam logic [1:0] MODE_CLEAR   = 2'd3;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] expect_word;
        logic [31:0] repl_word;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [7:0] value;
        logic       hit;
        logic       miss;
    } lane_res_t;

    // Big-endian lane select: lane 0 is the most significant byte.
    function automatic logic [7:0] lane_byte(input logic [31:0] word,
                                             input logic [LANE_W-1:0] lane);
        logic [7:0] b;
        case (lane)
            2'd0:    b = word[31:24];
            2'd1:    b = word[23:16];
            2'd2:    b = word[15:8];
            default: b = word[7:0];
        endcase
        return b;
    endfunction

endpackage

// File: hw/rtl/sbp_table_ram.sv
`timescale 1ns / 1ps

module sbp_table_ram #(
    parameter int DATA_W = 96,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/sbp_lane_check.sv
`timescale 1ns / 1ps

module sbp_lane_check (
    input  sbp_pkg::entry_t    entry,
    input  logic [31:0]        position,
    input  logic [7:0]         cur_byte,
    output sbp_pkg::lane_res_t res
);

    import sbp_pkg::*;

    logic [31:0]       offset;
    logic              covers;
    logic [LANE_W-1:0] lane;
    logic [7:0]        exp_byte;

    // Offset wraps modulo 2^32, so entries straddling the top also cover.
    assign offset   = position - entry.addr;
    assign covers   = (offset[31:LANE_W] == '0);
    assign lane     = offset[LANE_W-1:0];
    assign exp_byte = lane_byte(entry.expect_word, lane);

    always_comb begin
        res.value = cur_byte;
        res.hit   = 1'b0;
        res.miss  = 1'b0;
        if (covers) begin
            if (cur_byte == exp_byte) begin
                res.value = lane_byte(entry.repl_word, lane);
                res.hit   = 1'b1;
            end else begin
                res.miss  = 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/stream_byte_patcher.sv
`timescale 1ns / 1ps

// Stream byte patcher.
// Input channel (s_*): one item per byte or command, selected by s_mode:
//   data byte, load table entry, restart pass, clear table.
// Result channel (m_*): exactly one result item per input item, in order.
// Data bytes are checked against every table entry in table order; a covering
// entry whose expected byte matches the current value replaces it, otherwise
// m_mismatch is raised. Loads append to the table (m_load_rejected when full).
// Result path by item kind:
//   load, restart, clear, and data bytes with an empty table or in the skip
//   phase: result registered in the cycle after acceptance; one item per cycle
//   while the receiver takes results. Patched data bytes: the table memory
//   is read one entry per cycle through its single read port, and no new
//   item is accepted until the walk over all table entries has finished.
// The result sits in an output register; s_ready is high while no table walk
// is running and the output register is empty or being emptied, so a stalled
// receiver holds the input side once its one result is pending.
// Reset (aresetn low, synchronous) empties the table, zeroes the stream
// position and the skipped-chunk count and drops any pending result. The
// table memory itself is not cleared; entries beyond the fill count are
// never read.
module stream_byte_patcher (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_data_byte,
    input  logic        s_chunk_last,
    input  logic [31:0] s_entry_address,
    input  logic [31:0] s_entry_expected,
    input  logic [31:0] s_entry_replacement,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_data_out,
    output logic        m_patched,
    output logic        m_mismatch,
    output logic        m_load_rejected,
    output logic        m_last_out
);

    import sbp_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    // Control state
    logic              state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [31:0]       pos_reg, pos_next;
    logic [SKIP_W-1:0] skip_reg, skip_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              pend_reg, pend_next;
    logic              m_valid_reg, m_valid_next;

    // Walk working registers
    logic [31:0]       walk_pos_reg, walk_pos_next;
    logic [7:0]        cur_reg, cur_next;
    logic              pat_reg, pat_next;
    logic              mis_reg, mis_next;
    logic              last_reg, last_next;

    // Result register
    logic [7:0]        m_data_reg, m_data_next;
    logic              m_pat_reg, m_pat_next;
    logic              m_mis_reg, m_mis_next;
    logic              m_rej_reg, m_rej_next;
    logic              m_last_reg, m_last_next;

    logic              accept;
    logic              table_full;
    logic              start_walk;
    logic              finish;
    logic              wr_en;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    entry_t            rd_entry;
    entry_t            wr_entry;
    lane_res_t         chk;

    assign s_ready    = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept     = s_valid && s_ready;
    assign table_full = (count_reg >= CNT_W'(MAX_ENTRIES));

    // A walk starts for data bytes once the table holds entries and the
    // skip phase is over.
    assign start_walk = accept && (s_mode == MODE_DATA) && (count_reg != '0)
                        && (skip_reg >= SKIP_W'(SKIP_CHUNKS));

    // Last entry's data returns when everything has been issued.
    assign finish = (state_reg == ST_WALK) && pend_reg && (issue_reg == count_reg);

    assign wr_en    = accept && (s_mode == MODE_LOAD) && !table_full;
    assign wr_entry = '{addr: s_entry_address, expect_word: s_entry_expected,
                        repl_word: s_entry_replacement};

    // Issue entry 0 on the accepting edge, then one entry a cycle.
    assign rd_en   = start_walk || ((state_reg == ST_WALK) && (issue_reg < count_reg));
    assign rd_addr = start_walk ? '0 : issue_reg[IDX_W-1:0];

    sbp_table_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_entry = entry_t'(rd_data);

    sbp_lane_check u_check (
        .entry    (rd_entry),
        .position (walk_pos_reg),
        .cur_byte (cur_reg),
        .res      (chk)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        skip_next     = skip_reg;
        issue_next    = issue_reg;
        pend_next     = pend_reg;
        walk_pos_next = walk_pos_reg;
        cur_next      = cur_reg;
        pat_next      = pat_reg;
        mis_next      = mis_reg;
        last_next     = last_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        m_pat_next    = m_pat_reg;
        m_mis_next    = m_mis_reg;
        m_rej_next    = m_rej_reg;
        m_last_next   = m_last_reg;

        if (accept) begin
            // Default result: all zero; modes below fill in what applies.
            m_data_next = '0;
            m_pat_next  = 1'b0;
            m_mis_next  = 1'b0;
            m_rej_next  = 1'b0;
            m_last_next = 1'b0;
            unique case (s_mode)
                MODE_DATA: begin
                    if (start_walk) begin
                        // Hold the byte and advance the position now.
                        state_next    = ST_WALK;
                        issue_next    = CNT_W'(1);
                        pend_next     = 1'b1;
                        walk_pos_next = pos_reg;
                        pos_next      = pos_reg + 32'd1;
                        cur_next      = s_data_byte;
                        pat_next      = 1'b0;
                        mis_next      = 1'b0;
                        last_next     = s_chunk_last;
                    end else begin
                        m_valid_next = 1'b1;
                        m_data_next  = s_data_byte;
                        m_last_next  = s_chunk_last;
                        if ((count_reg != '0) && s_chunk_last) begin
                            skip_next = skip_reg + SKIP_W'(1);
                        end
                    end
                end
                MODE_LOAD: begin
                    m_valid_next = 1'b1;
                    if (table_full) begin
                        m_rej_next = 1'b1;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_RESTART: begin
                    m_valid_next = 1'b1;
                    pos_next     = '0;
                    skip_next    = SKIP_W'(SKIP_CHUNKS);
                end
                MODE_CLEAR: begin
                    m_valid_next = 1'b1;
                    count_next   = '0;
                    pos_next     = '0;
                    skip_next    = '0;
                end
                default: begin
                    m_valid_next = 1'b1;
                end
            endcase
        end else if (state_reg == ST_WALK) begin
            if (pend_reg) begin
                cur_next = chk.value;
                pat_next = pat_reg | chk.hit;
                mis_next = mis_reg | chk.miss;
            end
            if (issue_reg < count_reg) begin
                issue_next = issue_reg + CNT_W'(1);
                pend_next  = 1'b1;
            end else begin
                pend_next  = 1'b0;
            end
            if (finish) begin
                // Output register is free: it was free or draining at accept.
                state_next   = ST_IDLE;
                m_valid_next = 1'b1;
                m_data_next  = chk.value;
                m_pat_next   = pat_reg | chk.hit;
                m_mis_next   = mis_reg | chk.miss;
                m_rej_next   = 1'b0;
                m_last_next  = last_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pos_reg     <= '0;
            skip_reg    <= '0;
            issue_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            skip_reg    <= skip_next;
            issue_reg   <= issue_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        walk_pos_reg <= walk_pos_next;
        cur_reg      <= cur_next;
        pat_reg      <= pat_next;
        mis_reg      <= mis_next;
        last_reg     <= last_next;
        m_data_reg   <= m_data_next;
        m_pat_reg    <= m_pat_next;
        m_mis_reg    <= m_mis_next;
        m_rej_reg    <= m_rej_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_data_out      = m_data_reg;
    assign m_patched       = m_pat_reg;
    assign m_mismatch      = m_mis_reg;
    assign m_load_rejected = m_rej_reg;
    assign m_last_out      = m_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table depth");

    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |-> !m_valid_reg)
        else $error("walk finished while a result was still pending");

    a_walk_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> ((issue_reg != '0) && (issue_reg <= count_reg)))
        else $error("walk issue index out of range");

    a_walk_start: assert property (@(posedge aclk) disable iff (!aresetn)
        start_walk |=> ((state_reg == ST_WALK) && pend_reg && !m_valid_reg))
        else $error("walk did not start cleanly");
`endif

endmodule
